[hdl/sss_pkg.sv]
// Package for the sample set statistics block: field widths, item and result types,
// queue entry type and operation codes.
// No dependencies.
package sss_pkg;

  localparam int unsigned SAMPLE_BITS         = 16;
  localparam int unsigned MEAN_BITS           = 24;
  localparam int unsigned STD_BITS            = 23;
  localparam int unsigned COUNT_BITS          = 17;
  localparam int unsigned FRAC_BITS           = 8;
  localparam int unsigned MAX_COUNT_DEFAULT   = 65536;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  typedef logic signed [SAMPLE_BITS-1:0] sss_sample_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               carries_sample;
    logic               last;
  } sss_in_t;

  typedef struct packed {
    logic signed [15:0]           minimum;
    logic signed [15:0]           maximum;
    logic signed [MEAN_BITS-1:0]  mean_q8;
    logic        [STD_BITS-1:0]   std_dev_q8;
    logic        [COUNT_BITS-1:0] sample_count;
    logic                         set_empty;
    logic                         count_overflow;
  } sss_out_t;

  typedef enum logic [1:0] {
    OP_SAMPLE      = 2'd0,
    OP_SAMPLE_LAST = 2'd1,
    OP_LAST        = 2'd2
  } sss_op_e;

  typedef struct packed {
    sss_op_e     op;
    sss_sample_t sample;
  } sss_entry_t;

endpackage

[hdl/sss_front.sv]
// Front end of the sample set statistics block: accepts items and classifies them
// into queue entries. Depends on sss_pkg.
module sss_front
  import sss_pkg::*;
(
  input  logic       start_i,
  input  sss_in_t    item_i,
  input  logic       full_i,
  output logic       busy_o,
  output logic       push_o,
  output sss_entry_t entry_o
);

  always_comb begin
    busy_o         = full_i;
    push_o         = start_i && !full_i && (item_i.carries_sample || item_i.last);
    entry_o.sample = sss_sample_t'(item_i.sample);
    case ({item_i.carries_sample, item_i.last})
      2'b10:   entry_o.op = OP_SAMPLE;
      2'b11:   entry_o.op = OP_SAMPLE_LAST;
      default: entry_o.op = OP_LAST;
    endcase
  end

endmodule

[hdl/sss_queue.sv]
// Short queue between front and back end of the sample set statistics block.
// Depends on sss_pkg for the entry type.
module sss_queue
  import sss_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  sss_entry_t data_i,
  input  logic       pop_i,
  output sss_entry_t data_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [FillW-1:0] FillFull = FillW'(Depth);

  sss_entry_t       mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == FillFull);
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[hdl/sss_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// No package dependencies.
module sss_div #(
  parameter int unsigned NumW = 80,
  parameter int unsigned DenW = 34
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] dividend_i,
  input  logic [DenW-1:0] divisor_i,
  output logic            done_o,
  output logic [NumW-1:0] quotient_o
);

  localparam int unsigned IterW = $clog2(NumW);
  localparam logic [IterW-1:0] IterLast = IterW'(NumW - 1);

  logic             busy_q, done_q;
  logic [IterW-1:0] iter_q;
  logic [NumW-1:0]  num_q;
  logic [DenW-1:0]  rem_q, den_q;
  logic [DenW:0]    trial, diff;
  logic             fits;

  always_comb begin
    trial = {rem_q, num_q[NumW-1]};
    diff  = trial - {1'b0, den_q};
    fits  = (trial >= {1'b0, den_q});
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 1'b1;
        if (iter_q == IterLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[NumW-2:0], fits};
      rem_q <= fits ? DenW'(diff) : DenW'(trial);
    end
  end

endmodule

[hdl/sss_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle, floored.
// No package dependencies.
module sss_sqrt #(
  parameter int unsigned RootW = 23
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [2*RootW-1:0] radicand_i,
  output logic               done_o,
  output logic [RootW-1:0]   root_o
);

  localparam int unsigned IterW = $clog2(RootW);
  localparam logic [IterW-1:0] IterLast = IterW'(RootW - 1);

  logic               busy_q, done_q;
  logic [IterW-1:0]   iter_q;
  logic [2*RootW-1:0] x_q;
  logic [RootW:0]     rem_q;
  logic [RootW-1:0]   root_q;
  logic [RootW+2:0]   shifted, trial, diff;
  logic               fits;

  always_comb begin
    shifted = {rem_q, x_q[2*RootW-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    diff    = shifted - trial;
    fits    = (shifted >= trial);
  end

  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 1'b1;
        if (iter_q == IterLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= x_q << 2;
      rem_q  <= fits ? (RootW+1)'(diff) : (RootW+1)'(shifted);
      root_q <= {root_q[RootW-2:0], fits};
    end
  end

endmodule

[hdl/sss_back.sv]
// Back end of the sample set statistics block: accumulates samples and, on the last
// item of a set, works out mean and deviation. Depends on sss_pkg, sss_div, sss_sqrt.
module sss_back
  import sss_pkg::*;
#(
  parameter int unsigned MaxCount = MAX_COUNT_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  sss_entry_t entry_i,
  output logic       pop_o,
  output logic       result_valid_o,
  output sss_out_t   result_o
);

  localparam int unsigned CntW   = $clog2(MaxCount + 1);
  localparam int unsigned SumW   = SAMPLE_BITS + CntW;
  localparam int unsigned SqW    = 2 * SAMPLE_BITS - 2 + CntW;
  localparam int unsigned SqLoW  = SqW / 2;
  localparam int unsigned SqHiW  = SqW - SqLoW;
  localparam int unsigned DW     = CntW + SqW;
  localparam int unsigned DivNW  = DW + 2 * FRAC_BITS;
  localparam int unsigned DivVW  = 2 * CntW;
  localparam int unsigned MagW   = SumW;
  localparam int unsigned RootW  = STD_BITS;

  localparam logic [CntW-1:0]        CntLim    = CntW'(MaxCount);
  localparam logic [DivNW-1:0]       MeanNegLim = DivNW'(1) << (MEAN_BITS - 1);
  localparam logic [DivNW-1:0]       MeanPosLim = MeanNegLim - 1'b1;
  localparam logic [MEAN_BITS-1:0]   MeanMinV  = {1'b1, {(MEAN_BITS-1){1'b0}}};
  localparam logic [MEAN_BITS-1:0]   MeanMaxV  = {1'b0, {(MEAN_BITS-1){1'b1}}};
  localparam logic [STD_BITS-1:0]    StdMaxV   = {STD_BITS{1'b1}};
  localparam sss_sample_t            MinInit   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sss_sample_t            MaxInit   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [6:0] {
    S_ACC  = 7'b0000001,
    S_PREP = 7'b0000010,
    S_MUL1 = 7'b0000100,
    S_MUL2 = 7'b0001000,
    S_DIVM = 7'b0010000,
    S_DIVS = 7'b0100000,
    S_SQRT = 7'b1000000
  } sss_state_e;

  sss_state_e              state_q;
  logic [CntW-1:0]         cnt_q;
  logic signed [SumW-1:0]  sum_q;
  logic [SqW-1:0]          sq_q;
  sss_sample_t             min_q, max_q;
  logic                    ovf_q;
  logic                    result_valid_q;
  sss_out_t                result_q;

  logic [MagW-1:0]         smag_q;
  logic                    neg_q;
  logic [CntW+SqLoW-1:0]   pl_q;
  logic [DivVW-1:0]        n2_q;
  logic [DW-1:0]           nsq_q, d_q;
  logic [2*MagW-1:0]       ss_q;
  logic [MEAN_BITS-1:0]    mean_q;
  logic                    sat_q;

  logic                          has_sample, is_last;
  sss_sample_t                   s;
  logic signed [2*SAMPLE_BITS-1:0] sq_prod;
  logic [CntW+SqHiW-1:0]         ph;
  logic                          div_start, div_done;
  logic [DivNW-1:0]              div_num, div_quo;
  logic [DivVW-1:0]              div_den;
  logic                          sqrt_start, sqrt_done;
  logic [RootW-1:0]              root;
  logic [MEAN_BITS-1:0]          mean_val;

  always_comb begin
    has_sample = entry_i.op inside {OP_SAMPLE, OP_SAMPLE_LAST};
    is_last    = entry_i.op inside {OP_SAMPLE_LAST, OP_LAST};
    s          = entry_i.sample;
    sq_prod    = s * s;
    ph         = cnt_q * sq_q[SqW-1:SqLoW];
    pop_o      = (state_q == S_ACC) && valid_i;

    div_start = (state_q == S_MUL2) || ((state_q == S_DIVM) && div_done);
    if (state_q == S_MUL2) begin
      div_num = DivNW'({smag_q, {FRAC_BITS{1'b0}}}) +
                (neg_q ? DivNW'(CntW'(cnt_q - 1'b1)) : '0);
      div_den = DivVW'(cnt_q);
    end else begin
      div_num = {d_q, {(2*FRAC_BITS){1'b0}}};
      div_den = n2_q;
    end
    sqrt_start = (state_q == S_DIVS) && div_done;

    if (neg_q) begin
      mean_val = (div_quo > MeanNegLim) ? MeanMinV : MEAN_BITS'(~div_quo + 1'b1);
    end else begin
      mean_val = (div_quo > MeanPosLim) ? MeanMaxV : MEAN_BITS'(div_quo);
    end
  end

  sss_div #(
    .NumW(DivNW),
    .DenW(DivVW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (div_den),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  sss_sqrt #(
    .RootW(RootW)
  ) u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sqrt_start),
    .radicand_i(div_quo[2*RootW-1:0]),
    .done_o    (sqrt_done),
    .root_o    (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_ACC;
      cnt_q          <= '0;
      sum_q          <= '0;
      sq_q           <= '0;
      min_q          <= MinInit;
      max_q          <= MaxInit;
      ovf_q          <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= 1'b0;
      case (state_q)
        S_ACC: begin
          if (valid_i) begin
            if (has_sample) begin
              if (cnt_q < CntLim) begin
                cnt_q <= cnt_q + 1'b1;
                sum_q <= sum_q + SumW'(s);
                sq_q  <= sq_q + SqW'($unsigned(sq_prod));
                if (s < min_q) min_q <= s;
                if (s > max_q) max_q <= s;
              end else begin
                ovf_q <= 1'b1;
              end
            end
            if (is_last) state_q <= S_PREP;
          end
        end
        S_PREP: begin
          if (cnt_q == '0) begin
            result_valid_q <= 1'b1;
            ovf_q          <= 1'b0;
            min_q          <= MinInit;
            max_q          <= MaxInit;
            state_q        <= S_ACC;
          end else begin
            state_q <= S_MUL1;
          end
        end
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: state_q <= S_DIVM;
        S_DIVM: begin
          if (div_done) state_q <= S_DIVS;
        end
        S_DIVS: begin
          if (div_done) state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (sqrt_done) begin
            result_valid_q <= 1'b1;
            cnt_q          <= '0;
            sum_q          <= '0;
            sq_q           <= '0;
            min_q          <= MinInit;
            max_q          <= MaxInit;
            ovf_q          <= 1'b0;
            state_q        <= S_ACC;
          end
        end
        default: state_q <= S_ACC;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_PREP: begin
        if (cnt_q == '0) begin
          result_q <= {{($bits(sss_out_t)-2){1'b0}}, 1'b1, ovf_q};
        end else begin
          neg_q  <= sum_q[SumW-1];
          smag_q <= sum_q[SumW-1] ? MagW'(-sum_q) : MagW'(sum_q);
          pl_q   <= cnt_q * sq_q[SqLoW-1:0];
          n2_q   <= cnt_q * cnt_q;
        end
      end
      S_MUL1: begin
        nsq_q <= DW'(pl_q) + (DW'(ph) << SqLoW);
        ss_q  <= smag_q * smag_q;
      end
      S_MUL2: d_q <= nsq_q - DW'(ss_q);
      S_DIVM: begin
        if (div_done) mean_q <= mean_val;
      end
      S_DIVS: begin
        if (div_done) sat_q <= |div_quo[DivNW-1:2*RootW];
      end
      S_SQRT: begin
        if (sqrt_done) begin
          result_q <= {16'(min_q), 16'(max_q), mean_q,
                       sat_q ? StdMaxV : STD_BITS'(root),
                       COUNT_BITS'(cnt_q), 1'b0, ovf_q};
        end
      end
      default: ;
    endcase
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

[hdl/sample_set_statistics.sv]
// Top level of the sample set statistics block: front end, queue and back end.
// Depends on sss_pkg, sss_front, sss_queue, sss_back.
//
// Usage: drive item_i and raise start; the item is taken at a rising edge where
// start is high and busy is low. Each item carries one signed sample, an end-only
// marker, or both; an item with last set closes the set. Items with neither are
// dropped. Per set the block reports minimum, maximum, mean and population
// standard deviation (both Q8, floored), the sample count and the empty and
// overflow flags on result_o, with result_valid_o high for exactly one cycle.
// The receiver cannot stall; results must be taken in that cycle.
// Throughput: one sample per cycle while the back end accumulates. A queue of
// QueueDepth entries sits between the sides; busy rises only when it is full.
// An empty set raises the strobe from S_PREP once the back end has popped its last
// item. Otherwise the strobe follows states S_PREP, S_MUL1 and S_MUL2, then the
// bit-serial divider that runs two divisions of N quotient bits (N = 80 at the
// defaults) and then the 23-step square root.
// Samples beyond MaxCount in a set are dropped and flagged.
// Reset clears the queue and all accumulators; busy is low out of reset.
module sample_set_statistics
  import sss_pkg::*;
#(
  parameter int unsigned MaxCount   = MAX_COUNT_DEFAULT,
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEFAULT
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  sss_in_t  item_i,
  output logic     busy,
  output logic     result_valid_o,
  output sss_out_t result_o
);

  logic       push, q_full, q_empty, pop;
  sss_entry_t push_entry, head_entry;

  sss_front u_front (
    .start_i(start),
    .item_i (item_i),
    .full_i (q_full),
    .busy_o (busy),
    .push_o (push),
    .entry_o(push_entry)
  );

  sss_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_entry),
    .pop_i  (pop),
    .data_o (head_entry),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  sss_back #(
    .MaxCount(MaxCount)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (!q_empty),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule

[hdl/sss_checker.sv]
// Port-level checks for sample_set_statistics and the bind that attaches them.
// Depends on sss_pkg and the top level.
module sss_checker
  import sss_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     result_valid_i,
  input sss_out_t result_i
);

  a_result_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |=> !result_valid_i)
    else $error("results on consecutive cycles");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && result_i.set_empty |->
      result_i.minimum == '0 && result_i.maximum == '0 && result_i.mean_q8 == '0 &&
      result_i.std_dev_q8 == '0 && result_i.sample_count == '0)
    else $error("empty set result not all zero");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && !result_i.set_empty |->
      $signed(result_i.minimum) <= $signed(result_i.maximum) &&
      result_i.sample_count != '0)
    else $error("minimum above maximum or zero count");

  a_mean_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && !result_i.set_empty |->
      $signed(result_i.mean_q8) >= $signed({result_i.minimum, 8'h00}) &&
      $signed(result_i.mean_q8) <= $signed({result_i.maximum, 8'h00}))
    else $error("mean outside sample range");

endmodule

bind sample_set_statistics sss_checker u_sss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .result_valid_i(result_valid_o),
  .result_i      (result_o)
);
